/* design/paa_pkg.sv */
// ----------------------------------------------------------------------------
// paa_pkg: shared types and constants
// Item and result records, register indexes, codes and sequencer states for
// the periodic allocation advance block.
// ----------------------------------------------------------------------------
package paa_pkg;

  localparam int unsigned SYMBOL_TICKS_DEF      = 2880;
  localparam int unsigned SUBSLOTS_PER_FRAME_DEF = 48;
  localparam int unsigned TIME_W                 = 64;
  localparam int unsigned CFG_IDX_W              = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEVICE_ROLE = 2'd0,
    REG_MU_CODE     = 2'd1,
    REG_FRAME_ANCHOR = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    KIND_DOWN  = 2'd0,
    KIND_UP    = 2'd1,
    KIND_BIDIR = 2'd2,
    KIND_BAD   = 2'd3
  } alloc_kind_t;

  typedef enum logic [2:0] {
    REP_SINGLE     = 3'd0,
    REP_FRAMES     = 3'd1,
    REP_SUBSLOTS   = 3'd2,
    REP_FRAME_GRP  = 3'd3,
    REP_SUBSLOT_GRP = 3'd4
  } repeat_kind_t;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_BAD_TYPE     = 3'd1,
    ST_ZERO_DUR     = 3'd2,
    ST_SINGLE_PAST  = 3'd3,
    ST_ZERO_REP     = 3'd4,
    ST_UNKNOWN_REP  = 3'd5,
    ST_ZERO_PERIOD  = 3'd6,
    ST_EXPIRED      = 3'd7
  } status_t;

  localparam logic [7:0] NUM_UNLIMITED = 8'hFF;

  typedef struct packed {
    logic        in_active;
    logic [1:0]  alloc_kind;
    logic [15:0] down_len;
    logic [15:0] up_len;
    logic [2:0]  repeat_kind;
    logic [7:0]  repeat_count;
    logic [63:0] next_time_in;
    logic [63:0] init_time;
    logic [7:0]  validity_frames;
    logic [7:0]  initial_frame_num;
    logic [63:0] now_time;
  } item_t;

  typedef struct packed {
    logic        out_active;
    logic [63:0] next_time_out;
    logic [7:0]  next_frame_num;
    logic [2:0]  status;
  } result_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PREP,
    S_CALC,
    S_CHECK,
    S_GAP_START,
    S_DIV_GAP,
    S_VALID,
    S_DIV_FN,
    S_OUT
  } state_t;

endpackage

/* design/paa_stream_if.sv */
// ----------------------------------------------------------------------------
// paa_stream_if: valid/ready channel
// Carries one payload record per transfer.
// ----------------------------------------------------------------------------
interface paa_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* design/paa_div.sv */
// ----------------------------------------------------------------------------
// paa_div: shared 64-bit unsigned divider
// Restoring divider, one quotient bit per cycle; done pulses with quotient
// and remainder valid.
// ----------------------------------------------------------------------------
module paa_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [paa_pkg::TIME_W-1:0] dividend,
  input  logic [paa_pkg::TIME_W-1:0] divisor,
  output logic [paa_pkg::TIME_W-1:0] quot,
  output logic [paa_pkg::TIME_W-1:0] rem,
  output paa_pkg::div_stat_t         stat
);
  localparam int unsigned W   = paa_pkg::TIME_W;
  localparam int unsigned CNT_W = $clog2(W);

  logic [W-1:0]   dvs;
  logic [W-1:0]   part;
  logic [W-1:0]   q;
  logic [CNT_W-1:0] cnt;
  logic           busy;
  logic           done;
  logic [W:0]     trial;

  assign trial = {part, q[W-1]} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvs  <= divisor;
      part <= '0;
      q    <= dividend;
    end else if (busy) begin
      if (trial[W]) begin
        part <= {part[W-2:0], q[W-1]};
        q    <= {q[W-2:0], 1'b0};
      end else begin
        part <= trial[W-1:0];
        q    <= {q[W-2:0], 1'b1};
      end
    end
  end

  assign quot = q;
  assign rem  = part;
  assign stat = '{busy: busy, done: done};

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("divider done without a run");
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> !busy) else $error("divider restarted while busy");
  a_busy_bounded: assert property (@(posedge clk) disable iff (rst)
    busy && cnt == CNT_W'(W - 1) |=> !busy && done)
    else $error("divider ran past its last step");
endmodule

/* design/periodic_allocation_advance.sv */
// ----------------------------------------------------------------------------
// periodic_allocation_advance: next occurrence of a radio allocation
// Takes one allocation record with the current modem time and returns the
// advanced next occurrence, an active flag, a frame number and a status.
// ----------------------------------------------------------------------------
// Usage:
//   item   - sink channel, one allocation record per transfer.
//   result - source channel, exactly one result per item, in order.
//   cfg_we/cfg_index/cfg_data - register writes, only while idle.
// Sequence: inactive, rejected and single allocations go from the check
//   straight to the output; a repeating one whose next time lies before
//   now takes a divider run to advance by whole periods, and a repeating
//   one takes a run for the frame number when the validity check applies.
//   The shared restoring divider, one quotient bit a cycle, does both.
// Throughput: one item at a time; item.ready is high only while idle.
// Reset: rst (synchronous) clears the sequencer, the result valid and the
//   configuration registers to zero; the datapath registers are not reset.
// Stall: a finished result sits in the output register until taken; a
//   further result waits in the sequencer until that register is free.
// ----------------------------------------------------------------------------
module periodic_allocation_advance #(
  parameter int unsigned SYMBOL_TICKS       = paa_pkg::SYMBOL_TICKS_DEF,
  parameter int unsigned SUBSLOTS_PER_FRAME = paa_pkg::SUBSLOTS_PER_FRAME_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [paa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [paa_pkg::TIME_W-1:0]    cfg_data,
  paa_stream_if.sink                    item,
  paa_stream_if.source                  result
);
  localparam int unsigned W       = paa_pkg::TIME_W;
  localparam int unsigned SUB_W   = $clog2(SYMBOL_TICKS * 5 + 1);
  localparam int unsigned FRAME_W = $clog2(SYMBOL_TICKS * 5 * SUBSLOTS_PER_FRAME + 1);
  localparam int unsigned PER_W   = FRAME_W + 8;
  localparam int unsigned DT_W    = SUB_W + 16;

  logic        device_role;
  logic [2:0]  mu_code;
  logic [W-1:0] frame_zero_anchor;

  paa_pkg::item_t   it;
  paa_pkg::result_t res;
  paa_pkg::result_t out_reg;
  logic             out_valid;
  paa_pkg::state_t  state, state_next;

  logic [SUB_W-1:0]   sub;
  logic [FRAME_W-1:0] frame;
  logic [15:0]        dur;
  logic [DT_W-1:0]    dticks;
  logic [PER_W-1:0]   period;
  logic [W-1:0]       next;
  logic               fn_check;

  logic               div_start;
  logic [W-1:0]       div_a;
  logic [W-1:0]       div_b;
  logic [W-1:0]       div_q;
  logic [W-1:0]       div_r;
  paa_pkg::div_stat_t div_stat;

  logic [SUB_W-1:0]   sym;
  logic               in_ready;
  logic               load_out;
  logic [W-1:0]       single_end;
  logic [7:0]         fn;
  logic [7:0]         elapsed;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      device_role       <= 1'b0;
      mu_code           <= '0;
      frame_zero_anchor <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        paa_pkg::REG_DEVICE_ROLE:  device_role       <= cfg_data[0];
        paa_pkg::REG_MU_CODE:      mu_code           <= cfg_data[2:0];
        paa_pkg::REG_FRAME_ANCHOR: frame_zero_anchor <= cfg_data;
        default: ;
      endcase
    end
  end

  paa_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .quot     (div_q),
    .rem      (div_r),
    .stat     (div_stat)
  );

  assign fn_check = it.validity_frames != paa_pkg::NUM_UNLIMITED
                 && it.initial_frame_num != paa_pkg::NUM_UNLIMITED
                 && frame_zero_anchor != '0;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      paa_pkg::S_IDLE:  if (item.valid) state_next = paa_pkg::S_PREP;
      paa_pkg::S_PREP:  state_next = paa_pkg::S_CALC;
      paa_pkg::S_CALC:  state_next = paa_pkg::S_CHECK;
      paa_pkg::S_CHECK: begin
        if (!it.in_active || it.alloc_kind == paa_pkg::KIND_BAD
            || (dur == '0 && it.repeat_kind != paa_pkg::REP_SINGLE)
            || it.repeat_kind == paa_pkg::REP_SINGLE || it.repeat_count == '0
            || it.repeat_kind > paa_pkg::REP_SUBSLOT_GRP || period == '0) begin
          state_next = paa_pkg::S_OUT;
        end else if (it.next_time_in == '0 && it.init_time != '0) begin
          state_next = paa_pkg::S_VALID;
        end else if (it.next_time_in < it.now_time) begin
          state_next = paa_pkg::S_GAP_START;
        end else begin
          state_next = paa_pkg::S_VALID;
        end
      end
      paa_pkg::S_GAP_START: state_next = paa_pkg::S_DIV_GAP;
      paa_pkg::S_DIV_GAP:   if (div_stat.done) state_next = paa_pkg::S_VALID;
      paa_pkg::S_VALID:     state_next = fn_check ? paa_pkg::S_DIV_FN : paa_pkg::S_OUT;
      paa_pkg::S_DIV_FN:    if (div_stat.done) state_next = paa_pkg::S_OUT;
      paa_pkg::S_OUT:       if (!out_valid || result.ready) state_next = paa_pkg::S_IDLE;
      default:              state_next = paa_pkg::S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready  = 1'b0;
    div_start = 1'b0;
    load_out  = 1'b0;
    div_a     = next;
    div_b     = W'(period);
    case (state)
      paa_pkg::S_IDLE:      in_ready = 1'b1;
      paa_pkg::S_GAP_START: begin
        div_start = 1'b1;
        div_a     = it.now_time - next;
      end
      paa_pkg::S_VALID: begin
        div_start = fn_check;
        div_a     = next - frame_zero_anchor;
        div_b     = W'(frame);
      end
      paa_pkg::S_OUT:       load_out = !out_valid || result.ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= paa_pkg::S_IDLE;
    else     state <= state_next;
  end

  assign sym        = SUB_W'(SYMBOL_TICKS) >> mu_code;
  assign single_end = next + W'(dticks);
  assign fn         = div_q[7:0];
  assign elapsed    = fn - it.initial_frame_num;

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      paa_pkg::S_IDLE: begin
        if (item.valid) it <= item.data;
      end
      paa_pkg::S_PREP: begin
        sub   <= SUB_W'(sym * SUB_W'(5));
        next  <= it.next_time_in;
        if (it.alloc_kind == paa_pkg::KIND_DOWN
            || (it.alloc_kind == paa_pkg::KIND_BIDIR && !device_role)) begin
          dur <= it.down_len;
        end else begin
          dur <= it.up_len;
        end
        res <= '{out_active: 1'b0, next_time_out: it.next_time_in,
                 next_frame_num: 8'd0, status: paa_pkg::ST_OK};
      end
      paa_pkg::S_CALC: begin
        frame  <= FRAME_W'(FRAME_W'(sub) * FRAME_W'(SUBSLOTS_PER_FRAME));
        dticks <= DT_W'(dur) * DT_W'(sub);
      end
      paa_pkg::S_CHECK: begin
        if (it.repeat_kind == paa_pkg::REP_FRAMES
            || it.repeat_kind == paa_pkg::REP_FRAME_GRP) begin
          period <= PER_W'(it.repeat_count) * PER_W'(frame);
        end else begin
          period <= PER_W'(it.repeat_count) * PER_W'(sub);
        end
        if (!it.in_active) begin
          res.status <= paa_pkg::ST_OK;
        end else if (it.alloc_kind == paa_pkg::KIND_BAD) begin
          res.status <= paa_pkg::ST_BAD_TYPE;
        end else if (dur == '0 && it.repeat_kind != paa_pkg::REP_SINGLE) begin
          res.status <= paa_pkg::ST_ZERO_DUR;
        end else if (it.repeat_kind == paa_pkg::REP_SINGLE) begin
          if (single_end < it.now_time && next != '0) begin
            res.status <= paa_pkg::ST_SINGLE_PAST;
          end else begin
            res.out_active <= 1'b1;
          end
        end
      end
      default: ;
    endcase
    // Period is needed in CHECK for the repeating branches; it is computed
    // here a state earlier so the checks see a settled value.
    if (state == paa_pkg::S_CALC) begin
      if (it.repeat_kind == paa_pkg::REP_FRAMES
          || it.repeat_kind == paa_pkg::REP_FRAME_GRP) begin
        period <= PER_W'(it.repeat_count)
                * PER_W'(FRAME_W'(sub) * FRAME_W'(SUBSLOTS_PER_FRAME));
      end else begin
        period <= PER_W'(it.repeat_count) * PER_W'(sub);
      end
    end
    if (state == paa_pkg::S_CHECK && it.in_active && it.alloc_kind != paa_pkg::KIND_BAD
        && !(dur == '0) && it.repeat_kind != paa_pkg::REP_SINGLE) begin
      if (it.repeat_count == '0) begin
        res.status <= paa_pkg::ST_ZERO_REP;
      end else if (it.repeat_kind > paa_pkg::REP_SUBSLOT_GRP) begin
        res.status <= paa_pkg::ST_UNKNOWN_REP;
      end else if (period == '0) begin
        res.status <= paa_pkg::ST_ZERO_PERIOD;
      end else if (it.next_time_in == '0 && it.init_time != '0) begin
        next <= it.now_time + W'(period);
      end
    end
    if (state == paa_pkg::S_DIV_GAP && div_stat.done) begin
      // whole periods past now: now plus what is left of the last period
      next <= (div_r == '0) ? it.now_time : it.now_time + (W'(period) - div_r);
    end
    if (state == paa_pkg::S_VALID) begin
      res.out_active    <= 1'b1;
      res.next_time_out <= next;
    end
    if (state == paa_pkg::S_DIV_FN && div_stat.done) begin
      res.next_frame_num <= fn;
      if (elapsed >= it.validity_frames) begin
        res.out_active <= 1'b0;
        res.status     <= paa_pkg::ST_EXPIRED;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) out_reg <= res;
  end

  assign item.ready   = in_ready;
  assign result.valid = out_valid;
  assign result.data  = out_reg;

  a_take_then_prep: assert property (@(posedge clk) disable iff (rst)
    item.valid && item.ready |=> state == paa_pkg::S_PREP)
    else $error("accepted item did not start the sequence");
  a_div_running: assert property (@(posedge clk) disable iff (rst)
    (state == paa_pkg::S_DIV_GAP || state == paa_pkg::S_DIV_FN)
    |-> div_stat.busy || div_stat.done)
    else $error("waiting on an idle divider");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load_out |-> !out_valid || result.ready)
    else $error("result register overwritten before transfer");
endmodule

/* bench/periodic_allocation_advance_tb.sv */
// ----------------------------------------------------------------------------
// periodic_allocation_advance_tb: self-checking bench for the allocation advance
// Drives allocation records with random gaps, predicts each result in the bench
// and compares every transfer on the result channel field by field.
// ----------------------------------------------------------------------------
module periodic_allocation_advance_tb;
  import paa_pkg::*;

  localparam int unsigned SYM_TICKS  = SYMBOL_TICKS_DEF;
  localparam int unsigned SUB_FRAME  = SUBSLOTS_PER_FRAME_DEF;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [63:0] cfg_data;

  paa_stream_if #(.T(item_t))   item_ch ();
  paa_stream_if #(.T(result_t)) result_ch ();

  periodic_allocation_advance dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .item     (item_ch.sink),
    .result   (result_ch.source)
  );

  // bench copy of the registers
  logic        role_q;
  logic [2:0]  mu_q;
  logic [63:0] anchor_q;

  item_t   pending_items[$];
  result_t expected_results[$];
  int      mismatches;
  bit      stim_done;
  bit      drain_ok;
  bit      last_accept;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic result_t advance_alloc(item_t it);
    result_t     r;
    logic [63:0] sub, frame, dur, period, nxt, gap, k, fn, ticks;
    logic [7:0]  elapsed;
    bit          have_dur;
    r = '0;
    r.next_time_out = it.next_time_in;
    if (!it.in_active) return r;
    sub   = (64'(SYM_TICKS) >> mu_q) * 64'd5;
    frame = 64'(SUB_FRAME) * sub;
    have_dur = 1'b1;
    if (it.alloc_kind == KIND_DOWN || (it.alloc_kind == KIND_BIDIR && !role_q))
      dur = 64'(it.down_len);
    else if (it.alloc_kind == KIND_UP || (it.alloc_kind == KIND_BIDIR && role_q))
      dur = 64'(it.up_len);
    else begin
      have_dur = 1'b0;
      dur = '0;
    end
    if (!have_dur) begin
      r.status = ST_BAD_TYPE;
      return r;
    end
    if (dur == 0 && it.repeat_kind != REP_SINGLE) begin
      r.status = ST_ZERO_DUR;
      return r;
    end
    if (it.repeat_kind == REP_SINGLE) begin
      if ((it.next_time_in + dur * sub) < it.now_time && it.next_time_in != 0)
        r.status = ST_SINGLE_PAST;
      else
        r.out_active = 1'b1;
      return r;
    end
    if (it.repeat_count == 0) begin
      r.status = ST_ZERO_REP;
      return r;
    end
    if (it.repeat_kind == REP_FRAMES || it.repeat_kind == REP_FRAME_GRP)
      period = 64'(it.repeat_count) * frame;
    else if (it.repeat_kind == REP_SUBSLOTS || it.repeat_kind == REP_SUBSLOT_GRP)
      period = 64'(it.repeat_count) * sub;
    else begin
      r.status = ST_UNKNOWN_REP;
      return r;
    end
    if (period == 0) begin
      r.status = ST_ZERO_PERIOD;
      return r;
    end
    nxt = it.next_time_in;
    if (nxt == 0 && it.init_time != 0) begin
      nxt = it.now_time + period;
    end else if (nxt < it.now_time) begin
      gap = it.now_time - nxt;
      k = gap / period + ((gap % period) != 0 ? 64'd1 : 64'd0);
      nxt = nxt + k * period;
    end
    r.next_time_out = nxt;
    r.out_active = 1'b1;
    if (it.validity_frames != NUM_UNLIMITED && it.initial_frame_num != NUM_UNLIMITED
        && anchor_q != 0) begin
      ticks = nxt - anchor_q;
      fn = (ticks / frame) & 64'hFF;
      r.next_frame_num = fn[7:0];
      elapsed = fn[7:0] - it.initial_frame_num;
      if (elapsed >= it.validity_frames) begin
        r.out_active = 1'b0;
        r.status = ST_EXPIRED;
      end
    end
    return r;
  endfunction

  function automatic int gap_len();
    if ($urandom_range(0, 2) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 200);
    return $urandom_range(1, 4);
  endfunction

  // input transfers seen at the rising edge
  always @(posedge clk) begin
    last_accept = !rst && item_ch.valid && item_ch.ready;
    if (last_accept) expected_results.push_back(advance_alloc(item_ch.data));
  end

  // driver: one transfer per handshake, random gaps (possibly none) between items
  int send_gap;
  initial send_gap = 0;
  always @(negedge clk) begin
    if (rst) begin
      item_ch.valid <= 1'b0;
    end else if (item_ch.valid && !last_accept) begin
      // hold
    end else begin
      if (send_gap > 0) begin
        send_gap--;
        item_ch.valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        item_ch.data  <= pending_items.pop_front();
        item_ch.valid <= 1'b1;
        send_gap = gap_len();
      end else begin
        item_ch.valid <= 1'b0;
      end
    end
  end

  // monitor: sample at the rising edge, vary ready on the falling one
  always @(posedge clk) begin
    result_t got, want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      got = result_ch.data;
      if (expected_results.size() == 0) begin
        $error("result transfer with nothing expected");
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        if (got.out_active !== want.out_active) begin
          $error("out_active exp %0d got %0d", want.out_active, got.out_active);
          mismatches++;
        end
        if (got.next_time_out !== want.next_time_out) begin
          $error("next_time_out exp %0h got %0h", want.next_time_out, got.next_time_out);
          mismatches++;
        end
        if (got.next_frame_num !== want.next_frame_num) begin
          $error("next_frame_num exp %0d got %0d", want.next_frame_num, got.next_frame_num);
          mismatches++;
        end
        if (got.status !== want.status) begin
          $error("status exp %0d got %0d", want.status, got.status);
          mismatches++;
        end
      end
    end
  end

  int stall_left;
  initial stall_left = 0;
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      result_ch.ready <= 1'b0;
    end else if ($urandom_range(0, 3) == 0) begin
      stall_left = gap_len();
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= 1'b1;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic item_t random_alloc();
    item_t it;
    it = '0;
    it.in_active       = ($urandom_range(0, 9) != 0);
    it.alloc_kind      = alloc_kind_t'($urandom_range(0, 3));
    it.down_len        = $urandom_range(0, 7) == 0 ? 16'($urandom_range(0, 1)) : 16'($urandom());
    it.up_len          = $urandom_range(0, 7) == 0 ? 16'($urandom_range(0, 1)) : 16'($urandom());
    it.repeat_kind     = $urandom_range(0, 9) == 0 ? 3'($urandom_range(5, 7))
                                                   : 3'($urandom_range(0, 4));
    it.repeat_count    = $urandom_range(0, 15) == 0 ? 8'd0 : 8'($urandom());
    it.now_time        = $urandom_range(0, 5) == 0 ? rand64() : 64'($urandom()) << $urandom_range(0, 24);
    case ($urandom_range(0, 4))
      0: it.next_time_in = '0;
      1: it.next_time_in = rand64();
      2: it.next_time_in = it.now_time + $urandom_range(0, 100000);
      default: it.next_time_in = it.now_time - 64'($urandom()) * $urandom_range(1, 64);
    endcase
    it.init_time       = $urandom_range(0, 1) ? rand64() : '0;
    it.validity_frames = $urandom_range(0, 4) == 0 ? NUM_UNLIMITED : 8'($urandom());
    it.initial_frame_num = $urandom_range(0, 4) == 0 ? NUM_UNLIMITED : 8'($urandom());
    return it;
  endfunction

  task automatic wait_drained();
    while (pending_items.size() > 0 || item_ch.valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [63:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      REG_DEVICE_ROLE: role_q = val[0];
      REG_MU_CODE:     mu_q = val[2:0];
      default:         anchor_q = val;
    endcase
  endtask

  task automatic directed_set();
    item_t it;
    for (int i = 0; i < 22; i++) begin
      it = '0;
      it.in_active = 1'b1;
      it.alloc_kind = alloc_kind_t'(i % 4);
      it.down_len = (i == 1) ? 16'hFFFF : 16'd10;
      it.up_len = (i == 2) ? 16'hFFFF : 16'd7;
      it.repeat_kind = 3'(i % 8);
      it.repeat_count = (i == 5) ? 8'd0 : ((i == 9) ? 8'hFF : 8'd3);
      it.now_time = 64'd1_000_000;
      it.next_time_in = (i % 3 == 0) ? 64'd5000 : 64'd2_000_000;
      it.validity_frames = (i == 13) ? NUM_UNLIMITED : 8'd2;
      it.initial_frame_num = (i == 14) ? NUM_UNLIMITED : 8'd0;
      pending_items.push_back(it);
    end
    it = '0;                                   // inactive passthrough
    it.next_time_in = '1;
    pending_items.push_back(it);
    it.in_active = 1'b1; it.down_len = 16'd1;  // single ending before now
    it.next_time_in = 64'd1; it.now_time = '1;
    pending_items.push_back(it);
    it.repeat_kind = REP_SUBSLOTS; it.repeat_count = 8'd1;  // unset next, init set
    it.next_time_in = '0; it.init_time = 64'd9; it.now_time = 64'hFFFF_FFFF_FFFF_FF00;
    it.validity_frames = 8'd0; it.initial_frame_num = 8'd0;
    pending_items.push_back(it);
  endtask

  initial begin
    logic [2:0]  mu_set[5];
    logic [63:0] anc_set[5];
    mu_set = '{3'd0, 3'd7, 3'd3, 3'd6, 3'd1};
    anc_set = '{64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 64'd1, 64'd123456, 64'h8000_0000_0000_0000};
    mismatches = 0;
    role_q = 1'b0; mu_q = '0; anchor_q = '0;
    rst = 1'b1;
    cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    item_ch.valid = 1'b0; item_ch.data = '0;
    result_ch.ready = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    // reset values first, directed items
    directed_set();
    wait_drained();
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(REG_DEVICE_ROLE, 64'(ph % 2));
      write_reg(REG_MU_CODE, 64'(mu_set[ph]));
      write_reg(REG_FRAME_ANCHOR, anc_set[ph]);
      if (ph == 1) directed_set();
      for (int i = 0; i < 240; i++) pending_items.push_back(random_alloc());
      wait_drained();
    end
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #30_000_000;
    $display("Mismatches found");
    $finish;
  end
endmodule

/* filelist.f */
design/paa_pkg.sv
design/paa_stream_if.sv
design/paa_div.sv
design/periodic_allocation_advance.sv
bench/periodic_allocation_advance_tb.sv
